// ----- design/qstd_pkg.sv -----
// ----------------------------------------------------------------------------
// qstd_pkg
// Shared types, character codes and hex decode helpers for the query string
// tokenizer and URL decoder.
// ----------------------------------------------------------------------------
package qstd_pkg;

   // result kinds
   typedef enum logic [2:0] {
      KIND_KEY       = 3'd0,
      KIND_VALUE     = 3'd1,
      KIND_PAIR_OK   = 3'd2,
      KIND_PAIR_NOEQ = 3'd3,
      KIND_DISCARD   = 3'd4
   } kind_type;

   // escape phase
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_PCT    = 2'd1,
      PH_HELD   = 2'd2,
      PH_UNUSED = 2'd3
   } phase_type;

   // character codes
   localparam logic [7:0] CH_QMARK   = 8'h3F;  // '?'
   localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
   localparam logic [7:0] CH_EQUAL   = 8'h3D;  // '='
   localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
   localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
   localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '

   // default depth of the result queue (power of two, at least 4)
   localparam int QUEUE_DEPTH = 8;

   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } hex_type;

   // one hex digit, either case
   function automatic hex_type hex_of(input logic [7:0] c);
      hex_type r;
      r.ok  = 1'b1;
      r.nib = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.nib = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.nib = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.nib = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // two escape bytes to one byte; bad first digit gives zero,
   // bad second digit gives the first digit alone
   function automatic logic [7:0] decode_escape(input logic [7:0] first,
                                                input logic [7:0] second);
      hex_type hi;
      hex_type lo;
      hi = hex_of(first);
      lo = hex_of(second);
      if (!hi.ok) begin
         return 8'd0;
      end else if (!lo.ok) begin
         return {4'd0, hi.nib};
      end else begin
         return {hi.nib, lo.nib};
      end
   endfunction

endpackage

// ----- design/query_string_tokenizer_decoder_top.sv -----
// ----------------------------------------------------------------------------
// query_string_tokenizer_decoder_top
// Results of an item are written to the result queue when it is taken.
// Throughput: one item per cycle while the result queue has room for three;
// each item gives zero to three results, drained one per cycle with rsp_ready.
// Reset: synchronous, clears token state and empties the result queue.
// Splits a query string at '&' into key and URL-decoded value bytes with
// pair markers; the first '?' emits a discard marker.
// ----------------------------------------------------------------------------
module query_string_tokenizer_decoder_top #(
   parameter int QUEUE_DEPTH = qstd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_path,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] ROOM_LIMIT = CW'(QUEUE_DEPTH - 3);

   typedef struct packed {
      qstd_pkg::kind_type kind;
      logic [7:0]         data;
      logic               last;
   } entry_type;

   // token state
   logic                query_ff, query_in;
   logic                value_ff, value_in;
   qstd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          held_ff, held_in;

   // result queue
   entry_type         queue_ff [QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   entry_type res [3];
   logic [1:0] res_n;
   logic       push;
   logic       pop;

   assign req_ready = (count_ff <= ROOM_LIMIT);
   assign push      = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_kind     = queue_ff[rd_ptr_ff].kind;
   assign rsp_out_byte = queue_ff[rd_ptr_ff].data;
   assign rsp_run_last = queue_ff[rd_ptr_ff].last;

   // per-item decode: next state and up to three results
   always_comb begin
      query_in = query_ff;
      value_in = value_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      res_n    = 2'd0;
      for (int i = 0; i < 3; i++) begin
         res[i] = '{kind: qstd_pkg::KIND_KEY, data: 8'd0, last: 1'b0};
      end

      if (!query_ff && req_data_byte == qstd_pkg::CH_QMARK) begin
         query_in = 1'b1;
         value_in = 1'b0;
         phase_in = qstd_pkg::PH_IDLE;
         held_in  = 8'd0;
         res[res_n].kind = qstd_pkg::KIND_DISCARD;
         res_n = res_n + 2'd1;
      end else if (req_data_byte == qstd_pkg::CH_AMP) begin
         // token end
         if (value_in) begin
            if (phase_in == qstd_pkg::PH_HELD) begin
               if (held_in == qstd_pkg::CH_PLUS) begin
                  res[res_n].kind = qstd_pkg::KIND_VALUE;
                  res[res_n].data = qstd_pkg::CH_SPACE;
                  res_n = res_n + 2'd1;
               end else if (held_in != qstd_pkg::CH_PERCENT) begin
                  res[res_n].kind = qstd_pkg::KIND_VALUE;
                  res[res_n].data = held_in;
                  res_n = res_n + 2'd1;
               end
            end
            res[res_n].kind = qstd_pkg::KIND_PAIR_OK;
         end else begin
            res[res_n].kind = qstd_pkg::KIND_PAIR_NOEQ;
         end
         res_n = res_n + 2'd1;
         value_in = 1'b0;
         phase_in = qstd_pkg::PH_IDLE;
         held_in  = 8'd0;
      end else if (!value_ff) begin
         if (req_data_byte == qstd_pkg::CH_EQUAL) begin
            value_in = 1'b1;
         end else begin
            res[res_n].kind = qstd_pkg::KIND_KEY;
            res[res_n].data = req_data_byte;
            res_n = res_n + 2'd1;
         end
      end else if (phase_ff == qstd_pkg::PH_PCT) begin
         held_in  = req_data_byte;
         phase_in = qstd_pkg::PH_HELD;
      end else if (phase_ff == qstd_pkg::PH_HELD) begin
         res[res_n].kind = qstd_pkg::KIND_VALUE;
         res[res_n].data = qstd_pkg::decode_escape(held_ff, req_data_byte);
         res_n = res_n + 2'd1;
         phase_in = qstd_pkg::PH_IDLE;
         held_in  = 8'd0;
      end else begin
         phase_in = qstd_pkg::PH_IDLE;
         if (req_data_byte == qstd_pkg::CH_PERCENT) begin
            phase_in = qstd_pkg::PH_PCT;
         end else begin
            res[res_n].kind = qstd_pkg::KIND_VALUE;
            res[res_n].data = (req_data_byte == qstd_pkg::CH_PLUS) ?
                              qstd_pkg::CH_SPACE : req_data_byte;
            res_n = res_n + 2'd1;
         end
      end

      // end of path closes the open token and returns to reset state
      if (req_end_of_path) begin
         if (value_in) begin
            if (phase_in == qstd_pkg::PH_HELD) begin
               if (held_in == qstd_pkg::CH_PLUS) begin
                  res[res_n].kind = qstd_pkg::KIND_VALUE;
                  res[res_n].data = qstd_pkg::CH_SPACE;
                  res_n = res_n + 2'd1;
               end else if (held_in != qstd_pkg::CH_PERCENT) begin
                  res[res_n].kind = qstd_pkg::KIND_VALUE;
                  res[res_n].data = held_in;
                  res_n = res_n + 2'd1;
               end
            end
            res[res_n].kind = qstd_pkg::KIND_PAIR_OK;
         end else begin
            res[res_n].kind = qstd_pkg::KIND_PAIR_NOEQ;
         end
         res_n = res_n + 2'd1;
         value_in = 1'b0;
         phase_in = qstd_pkg::PH_IDLE;
         held_in  = 8'd0;
         query_in = 1'b0;
      end

      // flag the final result of this item
      if (res_n != 2'd0) begin
         res[res_n - 2'd1].last = 1'b1;
      end
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + AW'(res_n);
         count_in  = count_in + CW'(res_n);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
         count_in  = count_in - CW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff  <= 1'b0;
         value_ff  <= 1'b0;
         phase_ff  <= qstd_pkg::PH_IDLE;
         held_ff   <= 8'd0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            query_ff <= query_in;
            value_ff <= value_in;
            phase_ff <= phase_in;
            held_ff  <= held_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < res_n) begin
               queue_ff[wr_ptr_ff + AW'(i)] <= res[i];
            end
         end
      end
   end

endmodule
